>>> rtl/usv_pkg.sv
// Package for the UTF-8 stream validator: widths, decode constants,
// state and result types, and the counter output helper. No dependencies.
package usv_pkg;

    // Width of the line and column counters; the ports always carry 24 bits.
    localparam int COUNT_WIDTH = 24;
    localparam int OUT_WIDTH   = 24;
    localparam int EXT_WIDTH   = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;
    localparam int CP_WIDTH    = 21;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    // Lead byte ranges
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [7:0] ASCII_END = 8'h80;

    // Code point limits
    localparam logic [CP_WIDTH-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_WIDTH-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_WIDTH-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CP_WIDTH-1:0] CP_MIN3      = 21'h000800;
    localparam logic [CP_WIDTH-1:0] CP_MIN4      = 21'h010000;
    localparam logic [CP_WIDTH-1:0] CP_NEWLINE   = 21'h00000A;
    localparam logic [CP_WIDTH-1:0] CP_LINE_SEP  = 21'h002028;
    localparam logic [CP_WIDTH-1:0] CP_PARA_SEP  = 21'h002029;

    // Sequence lengths
    localparam logic [2:0] SEQ_LEN1 = 3'd1;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    typedef struct packed {
        logic [1:0]             bytes_remaining;
        logic [2:0]             sequence_length;
        logic [CP_WIDTH-1:0]    code_point;
        logic [COUNT_WIDTH-1:0] line_counter;
        logic [COUNT_WIDTH-1:0] column_counter;
        logic                   error_seen;
    } usv_state_t;

    localparam usv_state_t STATE_RESET = '{
        bytes_remaining: 2'd0,
        sequence_length: SEQ_LEN1,
        code_point:      '0,
        line_counter:    CNT_ONE,
        column_counter:  CNT_ONE,
        error_seen:      1'b0
    };

    typedef struct packed {
        logic                 status;
        logic [OUT_WIDTH-1:0] line_number;
        logic [OUT_WIDTH-1:0] column_number;
    } usv_result_t;

    // Low output bits of a counter, zero-extended when the counter is narrow
    function automatic logic [OUT_WIDTH-1:0] count_to_out(input logic [COUNT_WIDTH-1:0] cnt);
        logic [EXT_WIDTH-1:0] ext;
        ext = EXT_WIDTH'(cnt);
        return ext[OUT_WIDTH-1:0];
    endfunction

    // Saturating increment of a counter
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] cnt);
        return (cnt == CNT_MAX) ? cnt : cnt + CNT_ONE;
    endfunction

endpackage

>>> rtl/usv_stream_if.sv
// Valid/ready channel interfaces for the UTF-8 stream validator:
// byte input channel and result channel. Depends on usv_pkg.
interface usv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface usv_out_if;
    logic                       valid;
    logic                       ready;
    logic                       status;
    logic [usv_pkg::OUT_WIDTH-1:0] line_number;
    logic [usv_pkg::OUT_WIDTH-1:0] column_number;

    modport source (output valid, output status, output line_number, output column_number,
                    input ready);
    modport sink   (input valid, input status, input line_number, input column_number,
                    output ready);
endinterface

>>> rtl/usv_input_stage.sv
// Input register of the UTF-8 stream validator: holds one byte transaction
// until the decode stage consumes it. Depends on usv_pkg and usv_stream_if.
module usv_input_stage (
    input  logic       clk,
    input  logic       rst_n,
    usv_in_if.sink     in_stream,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_last
);
    import usv_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       take;

    // Accept when empty or when the held byte leaves this cycle
    assign in_stream.ready = !valid_reg || advance;
    assign take            = in_stream.valid && in_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_stream.data_byte;
            last_reg <= in_stream.end_of_text;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_last  = last_reg;
endmodule

>>> rtl/usv_decode.sv
// Per-byte decode logic of the UTF-8 stream validator: next decoder state
// and the end-of-text result from the current state. Depends on usv_pkg.
module usv_decode (
    input  usv_pkg::usv_state_t  state,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_text,
    output usv_pkg::usv_state_t  state_next,
    output usv_pkg::usv_result_t result,
    output logic                 has_result
);
    import usv_pkg::*;

    usv_state_t          taken;
    logic [CP_WIDTH-1:0] cp_shift;
    logic [CP_WIDTH-1:0] finish_cp;
    logic                finish_en;
    logic                cp_bad;

    // Append six payload bits of a continuation byte
    assign cp_shift = {state.code_point[CP_WIDTH-7:0], data_byte[5:0]};

    // Reject overlong forms, surrogates and values past the top plane
    assign cp_bad = ((state.sequence_length == SEQ_LEN3) && (cp_shift < CP_MIN3)) ||
                    ((state.sequence_length == SEQ_LEN4) && (cp_shift < CP_MIN4)) ||
                    ((cp_shift >= CP_SURR_LO) && (cp_shift <= CP_SURR_HI)) ||
                    (cp_shift > CP_MAX);

    always_comb
    begin
        taken     = state;
        finish_en = 1'b0;
        finish_cp = '0;
        if (!state.error_seen)
        begin
            if (state.bytes_remaining == 2'd0)
            begin
                // Classify lead byte
                priority if (data_byte < ASCII_END)
                begin
                    finish_en = 1'b1;
                    finish_cp = CP_WIDTH'(data_byte);
                end
                else if ((data_byte >= LEAD2_LO) && (data_byte <= LEAD2_HI))
                begin
                    taken.bytes_remaining = 2'd1;
                    taken.sequence_length = SEQ_LEN2;
                    taken.code_point      = CP_WIDTH'(data_byte[4:0]);
                end
                else if ((data_byte >= LEAD3_LO) && (data_byte <= LEAD3_HI))
                begin
                    taken.bytes_remaining = 2'd2;
                    taken.sequence_length = SEQ_LEN3;
                    taken.code_point      = CP_WIDTH'(data_byte[3:0]);
                end
                else if ((data_byte >= LEAD4_LO) && (data_byte <= LEAD4_HI))
                begin
                    taken.bytes_remaining = 2'd3;
                    taken.sequence_length = SEQ_LEN4;
                    taken.code_point      = CP_WIDTH'(data_byte[2:0]);
                end
                else
                begin
                    taken.error_seen = 1'b1;
                end
            end
            else if (data_byte[7:6] != 2'b10)
            begin
                taken.error_seen = 1'b1;
            end
            else
            begin
                // Continuation byte: extend the code point
                taken.code_point      = cp_shift;
                taken.bytes_remaining = state.bytes_remaining - 2'd1;
                if (state.bytes_remaining == 2'd1)
                begin
                    if (cp_bad)
                    begin
                        taken.error_seen = 1'b1;
                    end
                    else
                    begin
                        finish_en             = 1'b1;
                        finish_cp             = cp_shift;
                        taken.sequence_length = SEQ_LEN1;
                        taken.code_point      = '0;
                    end
                end
            end
        end

        // Advance line or column for a completed code point
        if (finish_en)
        begin
            if ((finish_cp == CP_NEWLINE) || (finish_cp == CP_LINE_SEP) ||
                (finish_cp == CP_PARA_SEP))
            begin
                taken.line_counter   = sat_inc(state.line_counter);
                taken.column_counter = CNT_ONE;
            end
            else
            begin
                taken.column_counter = sat_inc(state.column_counter);
            end
        end
    end

    // Report on the last byte, flag a cut-short sequence, then start over
    assign has_result           = end_of_text;
    assign result.status        = taken.error_seen || (taken.bytes_remaining != 2'd0);
    assign result.line_number   = count_to_out(taken.line_counter);
    assign result.column_number = count_to_out(taken.column_counter);
    assign state_next           = end_of_text ? STATE_RESET : taken;
endmodule

>>> rtl/usv_output_stage.sv
// Result register of the UTF-8 stream validator: holds one result
// transaction until the sink takes it. Depends on usv_pkg and usv_stream_if.
module usv_output_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    usv_out_if.source            out_stream,
    input  logic                 load,
    input  usv_pkg::usv_result_t load_result,
    output logic                 slot_free
);
    import usv_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    usv_result_t result_reg;

    // Room for a new result when empty or when the held one leaves now
    assign slot_free = !valid_reg || out_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_stream.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_stream.valid         = valid_reg;
    assign out_stream.status        = result_reg.status;
    assign out_stream.line_number   = result_reg.line_number;
    assign out_stream.column_number = result_reg.column_number;
endmodule

>>> rtl/utf8_stream_validator_core.sv
// Top level of the UTF-8 stream validator: input register, decode logic,
// decoder state and result register. Depends on usv_pkg, usv_stream_if,
// usv_input_stage, usv_decode and usv_output_stage.
//
// Checks a text for strict UTF-8, one byte transaction per clock unless
// in_stream stalls. Each byte waits in the input register; the decoder state
// updates as it leaves, and the byte marked end_of_text loads its result into
// the result register, which drives out_stream. The sustained rate is one
// byte per cycle, set by the combinational decode between the input register
// and the decoder state; in_stream stalls only while a finished result waits
// in the result register and another result is due. A result reports status
// 0 for valid text with the final line and column, or status 1 with the line
// and column of the first bad sequence's lead byte. Counters saturate; state
// returns to its reset values after each result.
module utf8_stream_validator_core (
    input  logic       clk,
    input  logic       rst_n,
    usv_in_if.sink     in_stream,
    usv_out_if.source  out_stream
);
    import usv_pkg::*;

    logic        held_valid;
    logic [7:0]  held_byte;
    logic        held_last;
    logic        advance;
    logic        slot_free;
    logic        has_result;
    usv_state_t  state_reg;
    usv_state_t  state_next;
    usv_result_t result;

    usv_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_last  (held_last)
    );

    usv_decode u_decode (
        .state       (state_reg),
        .data_byte   (held_byte),
        .end_of_text (held_last),
        .state_next  (state_next),
        .result      (result),
        .has_result  (has_result)
    );

    // Consume the held byte unless its result has nowhere to go
    assign advance = held_valid && (!has_result || slot_free);

    // Update decoder state as each byte is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    usv_output_stage u_output (
        .clk         (clk),
        .rst_n       (rst_n),
        .out_stream  (out_stream),
        .load        (advance && has_result),
        .load_result (result),
        .slot_free   (slot_free)
    );
endmodule

>>> rtl/usv_checker.sv
// Port-level checker for the UTF-8 stream validator, bound to the top level.
// Depends on usv_pkg and utf8_stream_validator_core.
module usv_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          in_last,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          out_status,
    input logic [usv_pkg::OUT_WIDTH-1:0] out_line,
    input logic [usv_pkg::OUT_WIDTH-1:0] out_column
);
    import usv_pkg::*;

    // Hold a stalled result transaction unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status) &&
        $stable(out_line) && $stable(out_column))
        else $error("result changed while stalled");

    // Stall input only under result back-pressure
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without result back-pressure");

    // A fresh result rises only after an end-of-text transaction has been
    // accepted and has passed the input register and the result register
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
        else $error("result without a preceding end of text");
endmodule

bind utf8_stream_validator_core usv_checker u_usv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_stream.valid),
    .in_ready   (in_stream.ready),
    .in_last    (in_stream.end_of_text),
    .out_valid  (out_stream.valid),
    .out_ready  (out_stream.ready),
    .out_status (out_stream.status),
    .out_line   (out_stream.line_number),
    .out_column (out_stream.column_number)
);
